// ----- hw/rtl/wms_pkg.sv -----
// Shared types and constants for the 802.11 management frame sniffer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wms_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int DEFAULT_MAX_SSID_BYTES = 32;
   localparam int DEFAULT_POSITION_BITS  = 12;

   // Frame layout
   localparam int HDR_BYTES    = 24;
   localparam int BEACON_FIXED = 12;
   localparam int SRC_FIRST    = 10;
   localparam int SRC_LAST     = 15;
   localparam int BSS_FIRST    = 16;
   localparam int BSS_LAST     = 21;
   localparam int SSID_SLOTS   = 32;

   // Frame control codes
   localparam logic [1:0] TYPE_MGMT      = 2'b00;
   localparam logic [3:0] SUBTYPE_PROBE  = 4'h4;
   localparam logic [3:0] SUBTYPE_BEACON = 4'h8;

   // Report kinds
   localparam logic KIND_PROBE  = 1'b0;
   localparam logic KIND_BEACON = 1'b1;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              frame_start;
      logic              frame_end;
      logic              is_mgmt_packet;
      logic signed [7:0] signal_strength;
      logic [3:0]        radio_channel;
      logic [31:0]       time_ms;
   } req_word_type;

   typedef struct packed {
      logic              frame_kind;
      logic [47:0]       source_mac;
      logic [47:0]       bssid_mac;
      logic signed [7:0] rssi_dbm;
      logic [3:0]        channel_num;
      logic [31:0]       stamp_ms;
      logic [5:0]        ssid_length;
      logic [63:0]       ssid_word0;
      logic [63:0]       ssid_word1;
      logic [63:0]       ssid_word2;
      logic [63:0]       ssid_word3;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- hw/rtl/wms_ifs.sv -----
// Valid/ready channel interfaces for the sniffer's byte input and report output.
// Depends on wms_pkg for the payload word types.
`default_nettype none

interface wms_req_if;
   import wms_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wms_rsp_if;
   import wms_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wlan_mgmt_frame_sniffer.sv -----
// A report appears in the output register in the cycle after its end byte.
// Throughput: one byte per cycle; input stalls only while a held report is not
// taken.
// Reset: synchronous, active high; clears the byte count, the frame state and
// the output valid. SSID and address captures need no reset.
// Depends on wms_pkg and the channel interfaces in wms_ifs.sv.
`default_nettype none

module wlan_mgmt_frame_sniffer #(
   parameter int MAX_SSID_BYTES = wms_pkg::DEFAULT_MAX_SSID_BYTES,
   parameter int POSITION_BITS  = wms_pkg::DEFAULT_POSITION_BITS
) (
   input  wire       clock,
   input  wire       reset,
   wms_req_if.sink   req_chan,
   wms_rsp_if.source rsp_chan
);
   import wms_pkg::*;

   // Compare width: holds the byte count and offset + 2 + a full length byte
   localparam int CmpW = ((POSITION_BITS > 9) ? POSITION_BITS : 9) + 1;
   localparam int IdxW = $clog2(MAX_SSID_BYTES);
   localparam logic [POSITION_BITS-1:0] PosLimit = {POSITION_BITS{1'b1}};
   localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_SSID_BYTES);

   // Frame state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]               fc_ff, fc_in;
   logic [7:0]               eid_ff, eid_in;
   logic [7:0]               elen_ff, elen_in;
   logic [47:0]              src_ff, src_in;
   logic [47:0]              bss_ff, bss_in;
   logic [7:0]               ssid_ff [MAX_SSID_BYTES];

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   // Per-byte working values
   req_word_type             word;
   logic                     req_acc;
   logic [POSITION_BITS-1:0] pos_cur;
   logic [7:0]               fc_cur, eid_cur, elen_cur;
   logic                     take;
   logic [CmpW-1:0]          idx_w, off_cur, off_nxt, rel, len_w;
   logic                     wr_en;
   logic [IdxW-1:0]          wr_idx;
   logic [3:0]               sub_nxt;
   logic                     report, ssid_ok;
   logic [5:0]               slen;
   logic [7:0]               ssid_view [SSID_SLOTS];
   logic [8*SSID_SLOTS-1:0]  ssid_flat;

   assign word           = req_chan.data;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // Start mark: treat the frame state as cleared before this byte
   always_comb begin
      pos_cur  = word.frame_start ? '0 : pos_ff;
      fc_cur   = word.frame_start ? '0 : fc_ff;
      eid_cur  = word.frame_start ? '0 : eid_ff;
      elen_cur = word.frame_start ? '0 : elen_ff;
   end

   // Capture this byte at its place in the frame
   always_comb begin
      take    = (pos_cur != PosLimit);
      idx_w   = CmpW'(pos_cur);
      off_cur = (fc_cur[7:4] == SUBTYPE_BEACON) ? CmpW'(HDR_BYTES + BEACON_FIXED)
                                                : CmpW'(HDR_BYTES);
      pos_in  = take ? pos_cur + 1'b1 : pos_cur;
      fc_in   = (take && idx_w == '0) ? word.data_byte : fc_cur;
      src_in  = (take && idx_w >= CmpW'(SRC_FIRST) && idx_w <= CmpW'(SRC_LAST))
                ? {src_ff[39:0], word.data_byte} : src_ff;
      bss_in  = (take && idx_w >= CmpW'(BSS_FIRST) && idx_w <= CmpW'(BSS_LAST))
                ? {bss_ff[39:0], word.data_byte} : bss_ff;
      eid_in  = (take && idx_w == off_cur) ? word.data_byte : eid_cur;
      elen_in = (take && idx_w == off_cur + CmpW'(1)) ? word.data_byte : elen_cur;
      rel     = idx_w - (off_cur + CmpW'(2));
      wr_en   = take && (idx_w >= off_cur + CmpW'(2)) && (rel < MaxLen);
      wr_idx  = rel[IdxW-1:0];
   end

   // Judge the frame with this byte included
   always_comb begin
      len_w   = CmpW'(pos_in);
      sub_nxt = fc_in[7:4];
      off_nxt = (sub_nxt == SUBTYPE_BEACON) ? CmpW'(HDR_BYTES + BEACON_FIXED)
                                            : CmpW'(HDR_BYTES);
      report  = word.frame_end && word.is_mgmt_packet
                && (len_w >= CmpW'(HDR_BYTES)) && (fc_in[3:2] == TYPE_MGMT)
                && (sub_nxt == SUBTYPE_PROBE || sub_nxt == SUBTYPE_BEACON);
      ssid_ok = (eid_in == 8'd0) && (CmpW'(elen_in) <= MaxLen)
                && (off_nxt + CmpW'(2) + CmpW'(elen_in) <= len_w);
      slen    = ssid_ok ? elen_in[5:0] : 6'd0;
   end

   // Overlay the byte written now and blank bytes past the SSID length
   always_comb begin
      for (int k = 0; k < SSID_SLOTS; k++) begin
         ssid_view[k] = 8'd0;
      end
      for (int k = 0; k < MAX_SSID_BYTES; k++) begin
         if (6'(k) < slen) begin
            ssid_view[k] = (wr_en && wr_idx == IdxW'(k)) ? word.data_byte : ssid_ff[k];
         end
      end
      for (int k = 0; k < SSID_SLOTS; k++) begin
         ssid_flat[8*k +: 8] = ssid_view[k];
      end
   end

   // Build the report word
   always_comb begin
      rsp_in.frame_kind  = (sub_nxt == SUBTYPE_BEACON) ? KIND_BEACON : KIND_PROBE;
      rsp_in.source_mac  = src_in;
      rsp_in.bssid_mac   = (sub_nxt == SUBTYPE_BEACON) ? bss_in : 48'd0;
      rsp_in.rssi_dbm    = word.signal_strength;
      rsp_in.channel_num = word.radio_channel;
      rsp_in.stamp_ms    = word.time_ms;
      rsp_in.ssid_length = slen;
      rsp_in.ssid_word0  = ssid_flat[63:0];
      rsp_in.ssid_word1  = ssid_flat[127:64];
      rsp_in.ssid_word2  = ssid_flat[191:128];
      rsp_in.ssid_word3  = ssid_flat[255:192];
   end

   // Output valid: load on a report, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc && report) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Advance the frame state; clear it after the end byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         fc_ff        <= '0;
         eid_ff       <= '0;
         elen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            if (word.frame_end) begin
               pos_ff  <= '0;
               fc_ff   <= '0;
               eid_ff  <= '0;
               elen_ff <= '0;
            end else begin
               pos_ff  <= pos_in;
               fc_ff   <= fc_in;
               eid_ff  <= eid_in;
               elen_ff <= elen_in;
            end
         end
      end
   end

   // Hold address captures, SSID store and report payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         src_ff <= src_in;
         bss_ff <= bss_in;
         if (wr_en) begin
            ssid_ff[wr_idx] <= word.data_byte;
         end
         if (report) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   // An end byte always leaves the next frame starting at byte zero
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.data.frame_end) |=> (pos_ff == '0))
      else $error("byte count not cleared after end byte");

   // A report never claims more SSID bytes than the store holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (6'(MAX_SSID_BYTES) >= rsp_chan.data.ssid_length))
      else $error("SSID length beyond store size");

   // Probe reports carry no BSSID
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.frame_kind == KIND_PROBE)
      |-> (rsp_chan.data.bssid_mac == 48'd0))
      else $error("probe report with BSSID");

   // A zero SSID length means the first and last SSID words are zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.ssid_length == 6'd0)
      |-> (rsp_chan.data.ssid_word0 == 64'd0 && rsp_chan.data.ssid_word3 == 64'd0))
      else $error("SSID bytes present with zero length");

   // A report only follows an accepted end byte
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_chan.valid)) |-> $past(req_acc && req_chan.data.frame_end))
      else $error("report without end byte");

endmodule

`default_nettype wire
